FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the echo delay RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition implies the consequent in the same cycle.
`define MTED_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition implies the consequent in the next cycle.
`define MTED_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/mted_pkg.sv
// ----------------------------------------------------------------------------
// mted_pkg
// Types and constants shared by the multi-tap echo delay modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mted_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int GAIN_W      = 16;
	localparam int TAP_COUNT_W = 3;
	localparam int SPACING_W   = 14;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 16;
	localparam int NUM_GAINS   = 6;
	localparam int MAX_TAPS    = 6;
	localparam int TAP_LIMIT   = (MAX_TAPS < NUM_GAINS) ? MAX_TAPS : NUM_GAINS;
	localparam int GAIN_IDX_W  = $clog2(NUM_GAINS);
	localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
	localparam int SCALED_W    = PROD_W - 15;
	localparam int ACC_W       = SCALED_W + 3;

	localparam int DEF_DELAY_DEPTH = 16384;

	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TAP_SPACING = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_0      = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_END         = CFG_IDX_W'(2 + NUM_GAINS);

	localparam logic [TAP_COUNT_W-1:0] RST_TAP_COUNT   = TAP_COUNT_W'(1);
	localparam logic [SPACING_W-1:0]   RST_TAP_SPACING = SPACING_W'(100);
	localparam logic [GAIN_W-1:0]      RST_GAIN_DRY    = GAIN_W'(32768);

	typedef struct packed {
		logic clear;
		logic valid;
	} mac_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/multi_tap_echo_delay_core.sv
// ----------------------------------------------------------------------------
// multi_tap_echo_delay_core
// Multi-tap feedforward echo: dry sample times gain 0 plus echoes read from a
// circular delay line, each scaled in Q1.15 and summed with saturation.
//
//   Channel  Direction  Handshake              Payload
//   in       sink       in_valid / in_ready    in_sample
//   out      source     out_valid / out_ready  out_sample
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item's result is registered once its taps are summed, and the next input
// transfer can follow in the cycle after. Before the taps, a fixed count of
// compare and subtract steps brings the spacing below the line depth, one at the
// default depth. Taps then issue one per cycle to the single multiplier, and the
// two-stage MAC pipeline drains. Reset needs no clearing pass because a fill
// count masks entries not yet written. A waiting result does not block the next
// input transfer, only the finish of the item after it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module multi_tap_echo_delay_core #(
	parameter int DELAY_DEPTH = mted_pkg::DEF_DELAY_DEPTH
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [mted_pkg::SAMPLE_W-1:0] in_sample,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed      [mted_pkg::SAMPLE_W-1:0] out_sample,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic        [mted_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic        [mted_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mted_pkg::*;

	localparam int AW = $clog2(DELAY_DEPTH);
	localparam int RW = ((AW > SPACING_W) ? AW : SPACING_W) + 1;
	localparam int RSTEPS = (SPACING_W >= AW) ? SPACING_W - AW + 1 : 1;
	localparam logic [RW-1:0] DEPTH_R = RW'(DELAY_DEPTH);
	localparam logic [RW-1:0] DV_INIT = DEPTH_R << (RSTEPS - 1);
	localparam logic [AW:0]   DEPTH_W = (AW+1)'(DELAY_DEPTH);
	localparam logic [AW-1:0] WP_LAST = AW'(DELAY_DEPTH - 1);
	localparam logic [TAP_COUNT_W-1:0] LIMIT = TAP_COUNT_W'(TAP_LIMIT);

	typedef enum logic [1:0] {
		S_IDLE,
		S_REDUCE,
		S_ISSUE,
		S_DRAIN
	} state_t;

	logic [TAP_COUNT_W-1:0] tap_count_q;
	logic [SPACING_W-1:0]   tap_spacing_q;
	logic [GAIN_W-1:0]      gain_q [NUM_GAINS];

	state_t                 state_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic [TAP_COUNT_W-1:0] last_q;
	logic [TAP_COUNT_W-1:0] k_q;
	logic [RW-1:0]          sp_q;
	logic [RW-1:0]          dv_q;
	logic [AW-1:0]          idx_q;
	logic [AW-1:0]          wp_q;
	logic                   valid_s1;
	logic                   dry_s1;
	logic [GAIN_W-1:0]      gain_s1;
	logic                   out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;

	logic [TAP_COUNT_W-1:0] taps_d;
	logic [AW:0]            idx_diff;
	logic [AW-1:0]          idx_next;
	logic                   in_xfer;
	logic                   pipe_empty;
	logic                   finish;
	logic                   rd_en;
	logic [SAMPLE_W-1:0]    rd_data;
	logic [GAIN_IDX_W-1:0]  gain_sel;
	logic [GAIN_IDX_W-1:0]  cfg_gain_idx;
	mac_ctl_t               mac_ctl;
	logic signed [SAMPLE_W-1:0] mac_operand;
	logic                   mac_busy;
	logic signed [SAMPLE_W-1:0] mac_result;

	// Configuration registers; writes are always taken.
	assign cfg_ready    = 1'b1;
	assign cfg_gain_idx = GAIN_IDX_W'(cfg_index - REG_GAIN_0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q   <= RST_TAP_COUNT;
			tap_spacing_q <= RST_TAP_SPACING;
			for (int i = 0; i < NUM_GAINS; i++) begin
				gain_q[i] <= (i == 0) ? RST_GAIN_DRY : '0;
			end
		end else if (cfg_valid) begin
			priority if (cfg_index == REG_TAP_COUNT) begin
				tap_count_q <= cfg_data[TAP_COUNT_W-1:0];
			end else if (cfg_index == REG_TAP_SPACING) begin
				tap_spacing_q <= cfg_data[SPACING_W-1:0];
			end else if ((cfg_index >= REG_GAIN_0) && (cfg_index < REG_END)) begin
				gain_q[cfg_gain_idx] <= cfg_data[GAIN_W-1:0];
			end else begin
				tap_count_q <= tap_count_q;
			end
		end
	end

	always_comb begin
		priority if (tap_count_q == '0) begin
			taps_d = TAP_COUNT_W'(1);
		end else if (tap_count_q > LIMIT) begin
			taps_d = LIMIT;
		end else begin
			taps_d = tap_count_q;
		end
	end

	assign idx_diff = {1'b0, idx_q} - {1'b0, sp_q[AW-1:0]};
	assign idx_next = idx_diff[AW] ? AW'(idx_diff + DEPTH_W) : idx_diff[AW-1:0];

	assign in_ready   = (state_q == S_IDLE);
	assign in_xfer    = in_valid && in_ready;
	assign pipe_empty = !valid_s1 && !mac_busy;
	assign finish     = (state_q == S_DRAIN) && pipe_empty && (!out_valid_q || out_ready);
	assign rd_en      = (state_q == S_ISSUE) && (k_q != '0);
	assign gain_sel   = GAIN_IDX_W'(k_q);

	assign mac_ctl.clear = in_xfer;
	assign mac_ctl.valid = valid_s1;
	assign mac_operand   = dry_s1 ? x_q : $signed(rd_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			x_q          <= '0;
			last_q       <= '0;
			k_q          <= '0;
			sp_q         <= '0;
			dv_q         <= '0;
			idx_q        <= '0;
			wp_q         <= '0;
			valid_s1     <= 1'b0;
			dry_s1       <= 1'b0;
			gain_s1      <= '0;
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
		end else begin
			valid_s1 <= (state_q == S_ISSUE);
			if (out_valid_q && out_ready && !finish) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						x_q     <= in_sample;
						last_q  <= taps_d - 1'b1;
						sp_q    <= RW'(tap_spacing_q);
						dv_q    <= DV_INIT;
						state_q <= S_REDUCE;
					end
				end
				S_REDUCE: begin
					if (sp_q >= dv_q) begin
						sp_q <= sp_q - dv_q;
					end
					if (dv_q == DEPTH_R) begin
						idx_q   <= wp_q;
						k_q     <= '0;
						state_q <= S_ISSUE;
					end else begin
						dv_q <= dv_q >> 1;
					end
				end
				S_ISSUE: begin
					dry_s1   <= (k_q == '0);
					gain_s1  <= gain_q[gain_sel];
					if (k_q != '0) begin
						idx_q <= idx_next;
					end
					if (k_q == last_q) begin
						state_q <= S_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (finish) begin
						out_valid_q  <= 1'b1;
						out_sample_q <= mac_result;
						wp_q         <= (wp_q == WP_LAST) ? '0 : wp_q + 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

	mted_dline #(
		.DEPTH(DELAY_DEPTH)
	) u_dline (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (finish),
		.wr_addr(wp_q),
		.wr_data(x_q),
		.rd_en  (rd_en),
		.rd_addr(idx_next),
		.rd_data(rd_data)
	);

	mted_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.operand(mac_operand),
		.gain   (gain_s1),
		.busy   (mac_busy),
		.result (mac_result)
	);

	`MTED_ASSERT_IMPL(a_tap_in_range, state_q == S_ISSUE,
		k_q <= last_q && last_q < LIMIT, "tap index beyond clamped tap count")
	`MTED_ASSERT_IMPL(a_spacing_reduced, state_q == S_ISSUE, sp_q < DEPTH_R,
		"echo spacing not reduced below line depth")
	`MTED_ASSERT_IMPL(a_ptr_in_range, 1'b1, wp_q <= WP_LAST && idx_q <= WP_LAST,
		"delay line pointer out of range")
	`MTED_ASSERT_NEXT(a_finish_loads_out, finish, out_valid_q && state_q == S_IDLE,
		"finished item did not reach output register")

endmodule

`default_nettype wire

FILE: hw/rtl/mted_dline.sv
// ----------------------------------------------------------------------------
// mted_dline
// Circular delay line memory with one write port and one registered read
// port. A fill count makes entries not yet written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mted_dline #(
	parameter int DEPTH = mted_pkg::DEF_DELAY_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
	input  wire logic [mted_pkg::SAMPLE_W-1:0] wr_data,
	input  wire logic                          rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
	output logic      [mted_pkg::SAMPLE_W-1:0] rd_data
);
	import mted_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

	logic [SAMPLE_W-1:0] mem_q [DEPTH];
	logic [SAMPLE_W-1:0] rd_q;
	logic                hit_q;
	logic [AW:0]         fill_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			hit_q  <= 1'b0;
		end else begin
			if (wr_en && (fill_q != DEPTH_W)) begin
				fill_q <= fill_q + 1'b1;
			end
			if (rd_en) begin
				hit_q <= ({1'b0, rd_addr} < fill_q);
			end
		end
	end

	assign rd_data = hit_q ? rd_q : '0;

endmodule

`default_nettype wire

FILE: hw/rtl/mted_mac.sv
// ----------------------------------------------------------------------------
// mted_mac
// Shared multiply-accumulate unit: one registered Q1.15 product per cycle,
// a wide accumulator and 16-bit saturation of the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module mted_mac (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire mted_pkg::mac_ctl_t                   ctl,
	input  wire logic signed [mted_pkg::SAMPLE_W-1:0] operand,
	input  wire logic        [mted_pkg::GAIN_W-1:0]   gain,
	output logic                                      busy,
	output logic signed      [mted_pkg::SAMPLE_W-1:0] result
);
	import mted_pkg::*;

	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

	logic signed [GAIN_W:0]   gain_sx;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     valid_s2;
	logic signed [SCALED_W-1:0] scaled;
	logic signed [ACC_W-1:0]  acc_q;

	assign gain_sx = $signed({1'b0, gain});
	assign scaled  = $signed(prod_s2[PROD_W-1:15]);

	always_ff @(posedge clk) begin
		prod_s2 <= operand * gain_sx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			acc_q    <= '0;
		end else begin
			valid_s2 <= ctl.valid;
			if (ctl.clear) begin
				acc_q <= '0;
			end else if (valid_s2) begin
				acc_q <= acc_q + ACC_W'(scaled);
			end
		end
	end

	always_comb begin
		priority if (acc_q > SAT_MAX) begin
			result = SAMPLE_W'(SAT_MAX);
		end else if (acc_q < SAT_MIN) begin
			result = SAMPLE_W'(SAT_MIN);
		end else begin
			result = acc_q[SAMPLE_W-1:0];
		end
	end

	assign busy = valid_s2;

endmodule

`default_nettype wire

FILE: tb/tb_multi_tap_echo_delay_core.sv
// ----------------------------------------------------------------------------
// tb_multi_tap_echo_delay_core
// Self-checking bench for the multi-tap echo core. Each input transfer is
// scored against a local Q1.15 echo mix with its own delay line and register
// copy. Each output transfer is compared with the oldest expected sample.
// Registers are reprogrammed between phases once the core has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_multi_tap_echo_delay_core;

	import mted_pkg::*;

	localparam int PTR_W       = $clog2(DEF_DELAY_DEPTH);
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 130;
	localparam int NUM_PHASES  = 12;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] in_sample = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] out_sample;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data  = '0;

	logic signed [SAMPLE_W-1:0] pending_q[$];
	logic signed [SAMPLE_W-1:0] expected_out_q[$];

	logic signed [SAMPLE_W-1:0] m_line [DEF_DELAY_DEPTH];
	logic [PTR_W-1:0]           m_wp;
	logic [TAP_COUNT_W-1:0]     m_tap_count;
	logic [SPACING_W-1:0]       m_spacing;
	logic [GAIN_W-1:0]          m_gain [NUM_GAINS];
	logic [GAIN_W-1:0]          plan_gain [NUM_GAINS];

	int  send_idle_pct = 16;
	int  recv_idle_pct = 57;
	int  errors        = 0;
	int  cycle_cnt     = 0;
	bit  drain_hold    = 1'b0;

	multi_tap_echo_delay_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_sample  (in_sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_sample (out_sample),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic longint q15_scale(input logic signed [SAMPLE_W-1:0] s,
			input logic [GAIN_W-1:0] g);
		longint p;
		p = longint'(s) * longint'({1'b0, g});
		return p >>> 15;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] mix_echo(
			input logic signed [SAMPLE_W-1:0] x);
		int               taps;
		longint           acc;
		logic [PTR_W-1:0] rd;
		taps = int'(m_tap_count);
		if (taps < 1)
			taps = 1;
		if (taps > TAP_LIMIT)
			taps = TAP_LIMIT;
		acc = q15_scale(x, m_gain[0]);
		for (int k = 1; k < taps; k++) begin
			rd = m_wp - PTR_W'(k * int'(m_spacing));
			acc += q15_scale(m_line[rd], m_gain[k]);
		end
		m_line[m_wp] = x;
		m_wp = m_wp + 1'b1;
		if (acc > 32767)
			acc = 32767;
		if (acc < -32768)
			acc = -32768;
		return SAMPLE_W'(acc);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] gen_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return SAMPLE_W'($urandom);
		else if (r == 7)
			return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
		else if (r == 8)
			return 16'sh7FFF;
		return 16'sh8000;
	endfunction

	function automatic logic [GAIN_W-1:0] gen_gain();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		else if (r == 1)
			return GAIN_W'(32768);
		else if (r == 2)
			return GAIN_W'($urandom_range(32769, 65535));
		return GAIN_W'($urandom_range(0, 32768));
	endfunction

	function automatic logic [SPACING_W-1:0] gen_spacing();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return SPACING_W'($urandom_range(1, 64));
		else if (r < 8)
			return SPACING_W'($urandom_range(65, 2000));
		else if (r == 8) begin
			case ($urandom_range(0, 2))
				0: return '0;
				1: return SPACING_W'(1);
				default: return '1;
			endcase
		end
		return SPACING_W'($urandom);
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_TAP_COUNT)
			m_tap_count = val[TAP_COUNT_W-1:0];
		else if (idx == REG_TAP_SPACING)
			m_spacing = val[SPACING_W-1:0];
		else if (idx >= REG_GAIN_0 && idx < REG_END)
			m_gain[idx - REG_GAIN_0] = val;
	endtask

	// Upper data bits above each register's width are filled at random.
	task automatic program_regs(input logic [TAP_COUNT_W-1:0] tc,
			input logic [SPACING_W-1:0] sp);
		cfg_write(REG_TAP_COUNT, {(CFG_DATA_W - TAP_COUNT_W)'($urandom), tc});
		cfg_write(REG_TAP_SPACING, {(CFG_DATA_W - SPACING_W)'($urandom), sp});
		for (int k = 0; k < NUM_GAINS; k++)
			cfg_write(CFG_IDX_W'(int'(REG_GAIN_0) + k), plan_gain[k]);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// The idle test runs at the falling edge, after the driver has settled.
	task automatic wait_idle();
		while (pending_q.size() != 0 || in_valid || expected_out_q.size() != 0)
			@(negedge clk);
		repeat (16)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_out_q.push_back(mix_echo(in_sample));
				if ($urandom_range(0, 99) == 0)
					drain_hold = 1'b1;
			end
			if (drain_hold && expected_out_q.size() == 0)
				drain_hold = 1'b0;
			if (!in_valid || in_ready) begin
				if (pending_q.size() != 0 && !drain_hold &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					in_valid  <= 1'b1;
					in_sample <= pending_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_out_q.size() == 0) begin
					$display("%0t: out_sample expected none, actual %0d", $time, out_sample);
					errors++;
				end else if (out_sample !== expected_out_q[0]) begin
					$display("%0t: out_sample expected %0d, actual %0d", $time,
						expected_out_q[0], out_sample);
					errors++;
					void'(expected_out_q.pop_front());
				end else begin
					void'(expected_out_q.pop_front());
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [TAP_COUNT_W-1:0] tc;
		logic [SPACING_W-1:0]   sp;
		for (int i = 0; i < DEF_DELAY_DEPTH; i++)
			m_line[i] = '0;
		m_wp        = '0;
		m_tap_count = RST_TAP_COUNT;
		m_spacing   = RST_TAP_SPACING;
		m_gain[0]   = RST_GAIN_DRY;
		for (int k = 1; k < NUM_GAINS; k++)
			m_gain[k] = '0;

		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Reset settings: the dry path alone at unity gain.
		pending_q.push_back(16'sh7FFF);
		pending_q.push_back(16'sh8000);
		pending_q.push_back(16'sh0000);
		pending_q.push_back(16'sh0001);
		pending_q.push_back(16'shFFFF);
		pending_q.push_back(16'sh4000);
		wait_idle();

		// Every gain near two with adjacent taps drives the sum into both rails.
		for (int k = 0; k < NUM_GAINS; k++)
			plan_gain[k] = '1;
		program_regs(TAP_COUNT_W'(6), SPACING_W'(1));
		repeat (3)
			pending_q.push_back(16'sh7FFF);
		repeat (3)
			pending_q.push_back(16'sh8000);
		wait_idle();

		// A tap count of zero still applies the dry tap, here with zero gain.
		plan_gain[0] = '0;
		for (int k = 1; k < NUM_GAINS; k++)
			plan_gain[k] = GAIN_W'(32768);
		program_regs('0, SPACING_W'(2));
		repeat (2)
			pending_q.push_back(gen_sample());
		wait_idle();

		// An oversized tap count with zero spacing reads the write location.
		plan_gain[0] = GAIN_W'(32768);
		program_regs('1, '0);
		repeat (3)
			pending_q.push_back(gen_sample());
		wait_idle();

		// Spacing past half the line wraps; stray indexes must not alias.
		for (int k = 0; k < NUM_GAINS; k++)
			plan_gain[k] = gen_gain();
		program_regs(TAP_COUNT_W'(6), SPACING_W'(8193));
		for (int i = int'(REG_END); i < (1 << CFG_IDX_W); i++)
			cfg_write(CFG_IDX_W'(i), (i % 2 == 0) ? '0 : CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
		repeat (4)
			pending_q.push_back(gen_sample());
		wait_idle();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph == NUM_PHASES / 3) begin
				send_idle_pct = 57;
				recv_idle_pct = 16;
			end else if (ph == 2 * NUM_PHASES / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph == 0) begin
				tc = TAP_COUNT_W'(6);
				sp = SPACING_W'(1);
				for (int k = 0; k < NUM_GAINS; k++)
					plan_gain[k] = GAIN_W'(32768);
			end else if (ph == NUM_PHASES - 1) begin
				tc = TAP_COUNT_W'(5);
				sp = '1;
				for (int k = 0; k < NUM_GAINS; k++)
					plan_gain[k] = GAIN_W'(16384);
			end else begin
				tc = TAP_COUNT_W'($urandom_range(0, 7));
				sp = gen_spacing();
				for (int k = 0; k < NUM_GAINS; k++)
					plan_gain[k] = gen_gain();
			end
			program_regs(tc, sp);
			repeat (PHASE_ITEMS)
				pending_q.push_back(gen_sample());
			wait_idle();
		end

		repeat (32)
			@(posedge clk);
		if (errors == 0 && expected_out_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/mted_pkg.sv
hw/rtl/mted_dline.sv
hw/rtl/mted_mac.sv
hw/rtl/multi_tap_echo_delay_core.sv
tb/tb_multi_tap_echo_delay_core.sv
